// File: src/range_max_query_2d_assert.svh
// ----------------------------------------------------------------------------
// range_max_query_2d assertion macros
// shared property forms for the rectangle maximum block
// ----------------------------------------------------------------------------
`ifndef RANGE_MAX_QUERY_2D_ASSERT_SVH
`define RANGE_MAX_QUERY_2D_ASSERT_SVH

// same-cycle implication
`define RMQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rmq same-cycle check failed");

// next-cycle implication
`define RMQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rmq next-cycle check failed");

`endif

// File: src/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// types, constants and helper functions of the 2d range maximum block
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

   localparam int MAX_ROWS       = 64;
   localparam int MAX_COLS       = 64;
   localparam int LEVELS         = 7;
   localparam int VALUE_BITS     = 32;
   localparam int FIELD_BITS     = 7;
   localparam int ROW_BITS       = $clog2(MAX_ROWS);
   localparam int COL_BITS       = $clog2(MAX_COLS);
   localparam int LVL_BITS       = $clog2(LEVELS);
   localparam int PAIR_BITS      = $clog2(LEVELS * LEVELS);
   localparam int GRID_DEPTH     = MAX_ROWS * MAX_COLS;
   localparam int TAB_DEPTH      = LEVELS * LEVELS * GRID_DEPTH;
   localparam int GRID_ADDR_BITS = $clog2(GRID_DEPTH);
   localparam int TAB_ADDR_BITS  = $clog2(TAB_DEPTH);
   localparam int CSR_INDEX_BITS = 1;

   typedef logic [FIELD_BITS-1:0]          coord_type;
   typedef logic signed [VALUE_BITS-1:0]   value_type;
   typedef logic [ROW_BITS-1:0]            row_type;
   typedef logic [COL_BITS-1:0]            col_type;
   typedef logic [LVL_BITS-1:0]            lvl_type;
   typedef logic [GRID_ADDR_BITS-1:0]      grid_addr_type;
   typedef logic [TAB_ADDR_BITS-1:0]       tab_addr_type;
   typedef logic [CSR_INDEX_BITS-1:0]      csr_index_type;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_BUILD = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   localparam csr_index_type CSR_ROWS = 1'b0;
   localparam csr_index_type CSR_COLS = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BLD_RD,
      ST_BLD_WR,
      ST_Q_RD0,
      ST_Q_RD1,
      ST_Q_FIN
   } state_type;

   typedef struct packed {
      logic capture;
      logic bld_mode;
      logic bld_write;
      logic q_phase1;
      logic q_latch;
      logic q_load;
   } cmd_type;

   typedef struct packed {
      logic bld_last;
      logic q_err;
      logic rsp_busy;
   } status_type;

   function automatic lvl_type lvl_of(input coord_type v);
      lvl_type k;
      k = '0;
      for (int b = 1; b < FIELD_BITS; b++) begin
         if (v[b]) k = LVL_BITS'(b);
      end
      if (k > LVL_BITS'(LEVELS - 1)) k = LVL_BITS'(LEVELS - 1);
      return k;
   endfunction

   function automatic coord_type eff_size(input coord_type v, input coord_type maxv);
      coord_type r;
      r = v;
      if (v == '0) r = coord_type'(1);
      else if (v > maxv) r = maxv;
      return r;
   endfunction

   function automatic coord_type pow2(input lvl_type k);
      return coord_type'(1) << k;
   endfunction

   function automatic tab_addr_type tix(input lvl_type i, input lvl_type j,
                                        input row_type r, input col_type c);
      logic [PAIR_BITS-1:0] p;
      p = PAIR_BITS'(i) * PAIR_BITS'(LEVELS) + PAIR_BITS'(j);
      return TAB_ADDR_BITS'({p, r, c});
   endfunction

   function automatic value_type vmax(input value_type a, input value_type b);
      return (a > b) ? a : b;
   endfunction

endpackage

`default_nettype wire

// File: src/rmq_req_if.sv
// ----------------------------------------------------------------------------
// rmq_req_if
// request channel: operation, bounds and cell value
// ----------------------------------------------------------------------------
`default_nettype none

interface rmq_req_if;
   import rmq_pkg::*;

   logic      valid;
   logic      ready;
   logic [1:0] operation;
   coord_type row_lo;
   coord_type col_lo;
   coord_type row_hi;
   coord_type col_hi;
   value_type cell_value;

   modport source (output valid, operation, row_lo, col_lo, row_hi, col_hi, cell_value,
                   input ready);
   modport sink (input valid, operation, row_lo, col_lo, row_hi, col_hi, cell_value,
                 output ready);
endinterface

`default_nettype wire

// File: src/rmq_rsp_if.sv
// ----------------------------------------------------------------------------
// rmq_rsp_if
// result channel: rectangle maximum and flags
// ----------------------------------------------------------------------------
`default_nettype none

interface rmq_rsp_if;
   import rmq_pkg::*;

   logic      valid;
   logic      ready;
   value_type rect_max;
   logic      corner_holds_max;
   logic      range_error;

   modport source (output valid, rect_max, corner_holds_max, range_error, input ready);
   modport sink (input valid, rect_max, corner_holds_max, range_error, output ready);
endinterface

`default_nettype wire

// File: src/rmq_ram.sv
// ----------------------------------------------------------------------------
// rmq_ram
// generic memory, one write port, two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic      [WIDTH-1:0]         rdata_a,
   output logic      [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule

`default_nettype wire

// File: src/rmq_ctrl.sv
// ----------------------------------------------------------------------------
// rmq_ctrl
// sequencer for cell writes, table build and rectangle queries
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic [1:0]          req_operation,
   input  wire rmq_pkg::status_type status,
   output logic                     req_ready,
   output rmq_pkg::cmd_type         cmd
);
   import rmq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == OP_BUILD) state_in = ST_BLD_RD;
               else if (req_operation == OP_QUERY) begin
                  state_in = status.q_err ? ST_Q_FIN : ST_Q_RD0;
               end
            end
         end
         ST_BLD_RD: state_in = ST_BLD_WR;
         ST_BLD_WR: state_in = status.bld_last ? ST_IDLE : ST_BLD_RD;
         ST_Q_RD0:  state_in = ST_Q_RD1;
         ST_Q_RD1:  state_in = ST_Q_FIN;
         ST_Q_FIN:  state_in = status.rsp_busy ? ST_Q_FIN : ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      cmd.capture   = (state_ff == ST_IDLE) && req_valid;
      cmd.bld_mode  = (state_ff == ST_BLD_RD) || (state_ff == ST_BLD_WR);
      cmd.bld_write = (state_ff == ST_BLD_WR);
      cmd.q_phase1  = (state_ff == ST_Q_RD1) || (state_ff == ST_Q_FIN);
      cmd.q_latch   = (state_ff == ST_Q_RD1);
      cmd.q_load    = (state_ff == ST_Q_FIN) && !status.rsp_busy;
   end

endmodule

`default_nettype wire

// File: src/rmq_datapath.sv
// ----------------------------------------------------------------------------
// rmq_datapath
// grid and table memories, build counters, query combine, result register
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_datapath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rmq_pkg::cmd_type       cmd,
   input  wire logic                   csr_wr_en,
   input  wire rmq_pkg::csr_index_type csr_index,
   input  wire rmq_pkg::coord_type     csr_wr_data,
   input  wire logic [1:0]             req_operation,
   input  wire rmq_pkg::coord_type     req_row_lo,
   input  wire rmq_pkg::coord_type     req_col_lo,
   input  wire rmq_pkg::coord_type     req_row_hi,
   input  wire rmq_pkg::coord_type     req_col_hi,
   input  wire rmq_pkg::value_type     req_cell_value,
   input  wire logic                   rsp_ready,
   output rmq_pkg::status_type         status,
   output logic                        rsp_valid,
   output rmq_pkg::value_type          rsp_rect_max,
   output logic                        rsp_corner_holds_max,
   output logic                        rsp_range_error
);
   import rmq_pkg::*;

   coord_type rows_ff, cols_ff;
   coord_type n_eff, m_eff;
   lvl_type   top_r, top_c;

   lvl_type bi_ff, bj_ff, bi_in, bj_in;
   row_type br_ff, br_in;
   col_type bc_ff, bc_in;

   row_type qr1_ff, qr2_ff, qrb_ff;
   col_type qc1_ff, qc2_ff, qcb_ff;
   lvl_type qt1_ff, qt2_ff;
   logic    qerr_ff;
   value_type pmax_ff, pcor_ff;

   logic      rsp_valid_ff;
   value_type rsp_max_ff;
   logic      rsp_cor_ff, rsp_err_ff;

   logic          grid_we;
   grid_addr_type grid_waddr, grid_ra, grid_rb;
   logic [VALUE_BITS-1:0] grid_da, grid_db, tab_da, tab_db;
   value_type     ga, gb, ta, tb;
   tab_addr_type  tab_ra, tab_rb, tab_waddr;
   value_type     tab_wdata;

   coord_type len_r, len_c, rb_full, cb_full;
   lvl_type   lt1, lt2;
   logic      q_err_now;
   lvl_type   jm1, im1;
   coord_type half_j, half_i;
   logic      c_last, r_last;
   value_type best, cor;

   assign n_eff = eff_size(rows_ff, coord_type'(MAX_ROWS));
   assign m_eff = eff_size(cols_ff, coord_type'(MAX_COLS));
   assign top_r = lvl_of(n_eff);
   assign top_c = lvl_of(m_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= coord_type'(MAX_ROWS);
         cols_ff <= coord_type'(MAX_COLS);
      end else if (csr_wr_en) begin
         if (csr_index == CSR_ROWS) rows_ff <= csr_wr_data;
         if (csr_index == CSR_COLS) cols_ff <= csr_wr_data;
      end
   end

   // query decode at accept
   always_comb begin
      q_err_now = (req_row_lo == '0) || (req_col_lo == '0) ||
                  (req_row_lo > req_row_hi) || (req_col_lo > req_col_hi) ||
                  (req_row_hi > n_eff) || (req_col_hi > m_eff);
      len_r   = req_row_hi - req_row_lo + coord_type'(1);
      len_c   = req_col_hi - req_col_lo + coord_type'(1);
      lt1     = lvl_of(len_r);
      lt2     = lvl_of(len_c);
      rb_full = req_row_hi - pow2(lt1);
      cb_full = req_col_hi - pow2(lt2);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         qr1_ff  <= row_type'(req_row_lo - coord_type'(1));
         qc1_ff  <= col_type'(req_col_lo - coord_type'(1));
         qr2_ff  <= row_type'(req_row_hi - coord_type'(1));
         qc2_ff  <= col_type'(req_col_hi - coord_type'(1));
         qrb_ff  <= rb_full[ROW_BITS-1:0];
         qcb_ff  <= cb_full[COL_BITS-1:0];
         qt1_ff  <= lt1;
         qt2_ff  <= lt2;
         qerr_ff <= q_err_now;
      end
   end

   // grid write at accept
   always_comb begin
      grid_we = cmd.capture && (req_operation == OP_WRITE) &&
                (req_row_lo != '0) && (req_row_lo <= coord_type'(MAX_ROWS)) &&
                (req_col_lo != '0) && (req_col_lo <= coord_type'(MAX_COLS));
      grid_waddr = {row_type'(req_row_lo - coord_type'(1)),
                    col_type'(req_col_lo - coord_type'(1))};
   end

   // build loop counters
   always_comb begin
      c_last = (coord_type'(bc_ff) + pow2(bj_ff)) == m_eff;
      r_last = (coord_type'(br_ff) + pow2(bi_ff)) == n_eff;
      bi_in = bi_ff;
      bj_in = bj_ff;
      br_in = br_ff;
      bc_in = bc_ff;
      if (!c_last) begin
         bc_in = bc_ff + col_type'(1);
      end else begin
         bc_in = '0;
         if (!r_last) begin
            br_in = br_ff + row_type'(1);
         end else begin
            br_in = '0;
            if (bj_ff != top_c) begin
               bj_in = bj_ff + lvl_type'(1);
            end else begin
               bj_in = '0;
               bi_in = bi_ff + lvl_type'(1);
            end
         end
      end
      status.bld_last = c_last && r_last && (bj_ff == top_c) && (bi_ff == top_r);
      status.q_err    = q_err_now;
      status.rsp_busy = rsp_valid_ff && !rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         bi_ff <= '0;
         bj_ff <= '0;
         br_ff <= '0;
         bc_ff <= '0;
      end else if (cmd.bld_write) begin
         bi_ff <= bi_in;
         bj_ff <= bj_in;
         br_ff <= br_in;
         bc_ff <= bc_in;
      end
   end

   // read addresses
   always_comb begin
      jm1    = bj_ff - lvl_type'(1);
      im1    = bi_ff - lvl_type'(1);
      half_j = pow2(jm1);
      half_i = pow2(im1);
      if (cmd.bld_mode) begin
         grid_ra = {br_ff, bc_ff};
         grid_rb = {br_ff, bc_ff};
         if (bi_ff == '0) begin
            tab_ra = tix('0, jm1, br_ff, bc_ff);
            tab_rb = tix('0, jm1, br_ff, bc_ff + half_j[COL_BITS-1:0]);
         end else begin
            tab_ra = tix(im1, bj_ff, br_ff, bc_ff);
            tab_rb = tix(im1, bj_ff, br_ff + half_i[ROW_BITS-1:0], bc_ff);
         end
      end else if (cmd.q_phase1) begin
         grid_ra = {qr2_ff, qc1_ff};
         grid_rb = {qr2_ff, qc2_ff};
         tab_ra  = tix(qt1_ff, qt2_ff, qr1_ff, qcb_ff);
         tab_rb  = tix(qt1_ff, qt2_ff, qrb_ff, qcb_ff);
      end else begin
         grid_ra = {qr1_ff, qc1_ff};
         grid_rb = {qr1_ff, qc2_ff};
         tab_ra  = tix(qt1_ff, qt2_ff, qr1_ff, qc1_ff);
         tab_rb  = tix(qt1_ff, qt2_ff, qrb_ff, qc1_ff);
      end
   end

   assign ga = grid_da;
   assign gb = grid_db;
   assign ta = tab_da;
   assign tb = tab_db;

   assign tab_waddr = tix(bi_ff, bj_ff, br_ff, bc_ff);
   assign tab_wdata = ((bi_ff == '0) && (bj_ff == '0)) ? ga : vmax(ta, tb);

   rmq_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (GRID_DEPTH)
   ) u_grid (
      .clock   (clock),
      .we      (grid_we),
      .waddr   (grid_waddr),
      .wdata   (req_cell_value),
      .raddr_a (grid_ra),
      .raddr_b (grid_rb),
      .rdata_a (grid_da),
      .rdata_b (grid_db)
   );

   rmq_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (TAB_DEPTH)
   ) u_table (
      .clock   (clock),
      .we      (cmd.bld_write),
      .waddr   (tab_waddr),
      .wdata   (tab_wdata),
      .raddr_a (tab_ra),
      .raddr_b (tab_rb),
      .rdata_a (tab_da),
      .rdata_b (tab_db)
   );

   // query combine
   always_ff @(posedge clock) begin
      if (cmd.q_latch) begin
         pmax_ff <= vmax(ta, tb);
         pcor_ff <= vmax(ga, gb);
      end
   end

   assign best = vmax(pmax_ff, vmax(ta, tb));
   assign cor  = vmax(pcor_ff, vmax(ga, gb));

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.q_load) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.q_load) begin
         rsp_max_ff <= qerr_ff ? '0 : best;
         rsp_cor_ff <= !qerr_ff && (cor == best);
         rsp_err_ff <= qerr_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_rect_max         = rsp_max_ff;
   assign rsp_corner_holds_max = rsp_cor_ff;
   assign rsp_range_error      = rsp_err_ff;

endmodule

`default_nettype wire

// File: src/range_max_query_2d.sv
// ----------------------------------------------------------------------------
// range_max_query_2d
// two-dimensional sparse table for rectangle maximum queries
// ----------------------------------------------------------------------------
// A cell write is taken at accept and gives no result. A query goes from
// accept through two reads (of two table entries and two grid corners each
// through the dual-read memories) to the combine and a loaded result; the
// load waits while an earlier result is not taken on rsp_chan.ready, and a
// bad query goes from accept straight to the load. A build takes, per table
// entry, a read of the two lower-level entries (the grid cell at the base
// level) and a write of the new maximum through the single table write port:
// a full 64 by 64 grid has 107584 entries. Both memories come up undefined
// and get no clearing pass; write every cell and build before querying. The
// next item is accepted while a result still waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module range_max_query_2d (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire rmq_pkg::csr_index_type csr_index,
   input  wire rmq_pkg::coord_type     csr_wr_data,
   rmq_req_if.sink                     req_chan,
   rmq_rsp_if.source                   rsp_chan
);
   import rmq_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       ready_w;

   rmq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_operation (req_chan.operation),
      .status        (status),
      .req_ready     (ready_w),
      .cmd           (cmd)
   );

   assign req_chan.ready = ready_w;

   rmq_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wr_data          (csr_wr_data),
      .req_operation        (req_chan.operation),
      .req_row_lo           (req_chan.row_lo),
      .req_col_lo           (req_chan.col_lo),
      .req_row_hi           (req_chan.row_hi),
      .req_col_hi           (req_chan.col_hi),
      .req_cell_value       (req_chan.cell_value),
      .rsp_ready            (rsp_chan.ready),
      .status               (status),
      .rsp_valid            (rsp_chan.valid),
      .rsp_rect_max         (rsp_chan.rect_max),
      .rsp_corner_holds_max (rsp_chan.corner_holds_max),
      .rsp_range_error      (rsp_chan.range_error)
   );

`include "range_max_query_2d_assert.svh"

   `RMQ_ASSERT_NOW(a_err_clean, clock, reset, rsp_chan.valid && rsp_chan.range_error, rsp_chan.rect_max == '0 && !rsp_chan.corner_holds_max)
   `RMQ_ASSERT_NOW(a_no_build_idle, clock, reset, ready_w, !cmd.bld_write)
   `RMQ_ASSERT_NEXT(a_write_one_cycle, clock, reset, req_chan.valid && ready_w && req_chan.operation == OP_WRITE, ready_w)

endmodule

`default_nettype wire
